FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL files of the LEB128 decoder.
// No dependencies; compiled away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ON(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_ON(lbl, clk, rst, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

FILE: hdl/leb_pkg.sv
// Types and codes for the LEB128 stream decoder.
// No dependencies; used by leb_step and leb128_stream_decoder_core.
`default_nettype none

package leb_pkg;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TAIL     = 2'd1,
    STATUS_OVERFLOW = 2'd2,
    STATUS_TRUNC    = 2'd3
  } leb_status_t;

  localparam int unsigned MaxBytes = 10;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
    logic       data_end;
  } leb_req_t;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  status;
    logic [3:0]  byte_count;
  } leb_res_t;

  typedef struct packed {
    logic [63:0] acc;
    logic [3:0]  bytes_seen;
    logic        previous_sign;
    logic        signed_mode;
  } leb_state_t;

endpackage

`default_nettype wire

FILE: hdl/leb_step.sv
// One decode step: folds a request byte into the running number state.
// Depends on leb_pkg.
`default_nettype none

module leb_step (
  input  leb_pkg::leb_state_t state,
  input  leb_pkg::leb_req_t   req,
  output leb_pkg::leb_state_t state_next,
  output logic                emit,
  output leb_pkg::leb_res_t   result
);
  import leb_pkg::*;

  logic [3:0]  bs;
  logic [3:0]  n;
  logic [5:0]  shamt;
  logic [6:0]  ext_sh;
  logic [6:0]  payload;
  logic        cont;
  logic        sign;
  logic        smode;
  logic        tail;
  logic        last_byte;
  logic [63:0] placed;
  logic [63:0] acc;
  logic [63:0] ext;

  always_comb begin
    bs        = (state.bytes_seen > 4'd9) ? 4'd9 : state.bytes_seen;
    n         = bs + 4'd1;
    shamt     = 6'({2'b00, bs} * 6'd7);
    ext_sh    = {1'b0, shamt} + 7'd7;
    payload   = req.data_byte[6:0];
    cont      = req.data_byte[7];
    sign      = req.data_byte[6];
    smode     = (state.bytes_seen == 4'd0) ? req.func : state.signed_mode;
    last_byte = (n == 4'(MaxBytes));
    // tenth byte lands at bit 63: only payload bit 0 survives the shift
    placed    = {57'd0, payload} << shamt;
    acc       = state.acc | placed;
    ext       = ~64'd0 << ext_sh;

    if (smode) begin
      tail = (bs != 4'd0) &&
             ((payload == 7'h7f && state.previous_sign) ||
              (payload == 7'h00 && !state.previous_sign));
    end else begin
      tail = (payload == 7'h00) && (bs != 4'd0);
    end

    emit       = 1'b0;
    result     = '0;
    state_next = '{acc: acc, bytes_seen: n,
                   previous_sign: smode ? sign : state.previous_sign,
                   signed_mode: smode};

    if (req.data_end) begin
      emit              = 1'b1;
      result.status     = STATUS_TRUNC;
      result.byte_count = state.bytes_seen;
    end else if (!smode) begin
      if (last_byte && req.data_byte != 8'h01) begin
        emit              = 1'b1;
        result.status     = STATUS_OVERFLOW;
        result.byte_count = n;
      end else if (!cont) begin
        emit              = 1'b1;
        result.value      = acc;
        result.status     = tail ? STATUS_TAIL : STATUS_OK;
        result.byte_count = n;
      end
    end else begin
      if (!cont) begin
        emit              = 1'b1;
        result.value      = (!last_byte && sign) ? (acc | ext) : acc;
        result.status     = tail ? STATUS_TAIL : STATUS_OK;
        result.byte_count = n;
      end else if (last_byte) begin
        emit              = 1'b1;
        result.status     = STATUS_OVERFLOW;
        result.byte_count = n;
      end
    end

    // every result returns the decoder to idle
    if (emit) begin
      state_next = '0;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/leb128_stream_decoder_core.sv
// Top level of the LEB128 stream decoder: request register, decode state, result register.
// Depends on leb_pkg, leb_step and assert_macros.svh.
//
// Decodes 64-bit unsigned or signed LEB128 numbers from a stream of one byte per
// request; func on a number's first byte picks signed decoding. A byte with bit 7
// clear completes the number and produces one result (value, status, byte_count);
// a request with data_end set aborts the number and reports truncation. Requests
// are taken at one per clock cycle for as long as the result side keeps up: the
// fold of each byte into the accumulator is combinational and sets that rate.
// An accepted request is held in the request register, and its result is loaded
// into the result register once the result side can take it.
// Stalling the result side stalls the request side only once a request that
// produces a result is waiting behind an untaken result.
`default_nettype none

`include "assert_macros.svh"

module leb128_stream_decoder_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              src_valid,
  output logic              src_stall,
  input  leb_pkg::leb_req_t src,
  output logic              res_valid,
  input  logic              res_stall,
  output leb_pkg::leb_res_t res
);
  import leb_pkg::*;

  logic       in_q_valid;
  leb_req_t   in_q;
  leb_state_t state;
  leb_state_t state_next;
  logic       step_emit;
  leb_res_t   step_res;
  logic       advance;

  leb_step u_step (
    .state      (state),
    .req        (in_q),
    .state_next (state_next),
    .emit       (step_emit),
    .result     (step_res)
  );

  assign advance   = in_q_valid && (!step_emit || !res_valid || !res_stall);
  assign src_stall = in_q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
      res_valid  <= 1'b0;
      state      <= '0;
    end else begin
      if (!src_stall) begin
        in_q_valid <= src_valid;
      end
      if (advance) begin
        state <= state_next;
      end
      if (advance && step_emit) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!src_stall) begin
      in_q <= src;
    end
    if (advance && step_emit) begin
      res <= step_res;
    end
  end

  `ASSERT_NEVER(a_bytes_range, clk, rst, state.bytes_seen > 4'd9, "bytes_seen past nine")
  `ASSERT_ON(a_ovf_shape, clk, rst, (res_valid && res.status == STATUS_OVERFLOW) |-> (res.byte_count == 4'd10 && res.value == 64'd0), "overflow result malformed")
  `ASSERT_ON(a_clear_after_emit, clk, rst, (advance && step_emit) |=> (state.bytes_seen == 4'd0 && state.acc == 64'd0), "state not cleared after result")
  `ASSERT_ON(a_stall_needs_item, clk, rst, src_stall |-> (in_q_valid && step_emit && res_valid), "request stalled without pending result")

endmodule

`default_nettype wire
